// ----- src/swm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants of the sliding window median unit.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int SAMPLE_W       = 32;
    localparam int CFG_W          = 7;
    localparam int MAX_WINDOW_DEF = 64;
    localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = 7'd3;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        S_IDLE,
        S_INSERT,
        S_DELETE,
        S_OUT
    } state_t;

    // Operation applied to every cell of the sorted chain.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_CLEAR
    } cell_op_t;

    // Cell i to cell i+1.
    typedef struct packed {
        logic    gt;
        logic    valid;
        sample_t value;
    } swm_up_t;

    // Cell i+1 to cell i.
    typedef struct packed {
        logic    valid;
        logic    eq;
        sample_t value;
    } swm_dn_t;

endpackage

// ----- src/swm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_ram
// Generic simple dual port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module swm_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/swm_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_cell
// One slot of the sorted sample chain: holds one sample and its valid bit,
// inserts and deletes by trading values with its two neighbors.
// ----------------------------------------------------------------------------
module swm_cell #(
    parameter int IDX    = 0,
    parameter int RANK_W = 6
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  swm_pkg::cell_op_t            op,
    input  swm_pkg::sample_t             x,
    input  swm_pkg::sample_t             d,
    input  logic [RANK_W-1:0]            rank,
    input  swm_pkg::swm_up_t             lo_in,
    input  swm_pkg::swm_dn_t             hi_in,
    output swm_pkg::swm_up_t             up_out,
    output swm_pkg::swm_dn_t             dn_out,
    output logic                         valid,
    output logic [swm_pkg::SAMPLE_W-1:0] tap
);
    import swm_pkg::*;

    sample_t value_reg;
    sample_t value_next;
    logic    valid_reg;
    logic    valid_next;
    logic    gt;
    logic    eq;
    logic    shift;

    // Slots past the fill act as +infinity.
    assign gt    = !valid_reg || (x < value_reg);
    assign eq    = valid_reg && (value_reg == d);
    // Slots above the deleted one, and the last copy of d, take from above.
    assign shift = !valid_reg || (value_reg > d) || (eq && !hi_in.eq);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        case (op)
            CELL_INSERT:
            begin
                if (gt)
                begin
                    value_next = lo_in.gt ? lo_in.value : x;
                end
                valid_next = valid_reg || lo_in.valid;
            end
            CELL_DELETE:
            begin
                if (shift)
                begin
                    value_next = hi_in.value;
                    valid_next = hi_in.valid;
                end
            end
            CELL_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                value_next = value_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign up_out.gt    = gt;
    assign up_out.valid = valid_reg;
    assign up_out.value = value_reg;
    assign dn_out.valid = valid_reg;
    assign dn_out.eq    = eq;
    assign dn_out.value = value_reg;
    assign valid        = valid_reg;
    assign tap          = (valid_reg && (rank == RANK_W'(IDX))) ? value_reg : '0;

endmodule

// ----- src/sliding_window_median_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_median_unit
// Lower median of the most recent window_size samples of a stream.
//
// Input beats (sample, last_of_sequence) come in on in_valid/in_ready. Once
// the window holds window_size samples, each beat yields one median beat on
// out_valid/out_ready; earlier beats yield none. A beat with last_of_sequence
// set empties the window once it is processed.
// Samples are kept sorted in a chain of MAX_WINDOW cells; a beat steps
// through accept, insert, delete of the oldest sample (read back from a
// ring RAM) with rank capture into a registered OR tree, and output. A beat
// that yields no median skips the delete and output; a new beat is accepted
// only once the previous one is through its steps.
// The next beat is accepted while a median still waits in the output
// register; a stalled receiver holds the block only at its output step.
// window_size is written on cfg_valid/cfg_ready while idle; a write also
// empties the window. Zero acts as 1, values above MAX_WINDOW saturate.
// Reset empties the window and sets window_size to 3; no clearing pass.
// ----------------------------------------------------------------------------
module sliding_window_median_unit #(
    parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [swm_pkg::SAMPLE_W-1:0] sample,
    input  logic                         last_of_sequence,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [swm_pkg::SAMPLE_W-1:0] median,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [swm_pkg::CFG_W-1:0]    window_size
);
    import swm_pkg::*;

    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int EW = (CW > CFG_W) ? CW : CFG_W;
    localparam int NG = (MAX_WINDOW + 7) / 8;

    state_t              state_reg;
    state_t              state_next;
    logic [CW-1:0]       fill_reg;
    logic [AW-1:0]       oldest_reg;
    logic [CFG_W-1:0]    window_size_reg;
    sample_t             x_reg;
    logic                last_reg;
    logic                produce_reg;
    logic [SAMPLE_W-1:0] group_reg [NG];
    logic [SAMPLE_W-1:0] group_next [NG];
    logic [SAMPLE_W-1:0] median_reg;
    logic                out_valid_reg;

    logic                in_fire;
    logic                cfg_fire;
    logic                out_load;
    cell_op_t            cell_op;
    logic                ram_re;

    logic [EW-1:0]       ws_ext;
    logic [EW-1:0]       w_eff_ext;
    logic [CW-1:0]       w_eff;
    logic [AW-1:0]       rank;
    logic [CW-1:0]       fill_p1;
    logic [AW:0]         tail_sum;
    logic [AW-1:0]       tail_slot;
    logic [AW-1:0]       oldest_inc;
    logic [SAMPLE_W-1:0] ram_rdata;
    logic [SAMPLE_W-1:0] final_or;

    swm_up_t             up_link [MAX_WINDOW+1];
    swm_dn_t             dn_link [MAX_WINDOW+1];
    logic [MAX_WINDOW-1:0] cell_valid;
    logic [SAMPLE_W-1:0] tap [MAX_WINDOW];

    // Window size and rank of the lower median.
    assign ws_ext    = EW'(window_size_reg);
    assign w_eff_ext = (ws_ext == '0) ? EW'(1) :
                       (ws_ext > EW'(MAX_WINDOW)) ? EW'(MAX_WINDOW) : ws_ext;
    assign w_eff     = CW'(w_eff_ext);
    assign rank      = AW'((w_eff - CW'(1)) >> 1);

    assign fill_p1   = fill_reg + CW'(1);
    assign tail_sum  = {1'b0, oldest_reg} + (AW+1)'(fill_reg);
    assign tail_slot = (tail_sum >= (AW+1)'(MAX_WINDOW)) ?
                       AW'(tail_sum - (AW+1)'(MAX_WINDOW)) : AW'(tail_sum);
    assign oldest_inc = (oldest_reg == AW'(MAX_WINDOW - 1)) ? '0 : oldest_reg + AW'(1);

    assign cfg_ready = (state_reg == S_IDLE);
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        cell_op    = CELL_HOLD;
        ram_re     = 1'b0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = !cfg_valid;
                if (cfg_fire)
                begin
                    cell_op = CELL_CLEAR;
                end
                else if (in_valid)
                begin
                    state_next = S_INSERT;
                end
            end
            S_INSERT:
            begin
                cell_op    = CELL_INSERT;
                ram_re     = 1'b1;
                state_next = S_DELETE;
            end
            S_DELETE:
            begin
                if (last_reg)
                begin
                    cell_op = CELL_CLEAR;
                end
                else if (produce_reg)
                begin
                    cell_op = CELL_DELETE;
                end
                state_next = produce_reg ? S_OUT : S_IDLE;
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            fill_reg        <= '0;
            oldest_reg      <= '0;
            window_size_reg <= WINDOW_SIZE_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_fire)
            begin
                window_size_reg <= window_size;
                fill_reg        <= '0;
                oldest_reg      <= '0;
            end
            else if (state_reg == S_DELETE)
            begin
                if (last_reg)
                begin
                    fill_reg   <= '0;
                    oldest_reg <= '0;
                end
                else if (produce_reg)
                begin
                    oldest_reg <= oldest_inc;
                end
                else
                begin
                    fill_reg <= fill_p1;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Beat payload and result registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            x_reg       <= sample_t'(sample);
            last_reg    <= last_of_sequence;
            produce_reg <= (fill_p1 >= w_eff);
        end
        if ((state_reg == S_DELETE) && produce_reg)
        begin
            for (int g = 0; g < NG; g++)
            begin
                group_reg[g] <= group_next[g];
            end
        end
        if (out_load)
        begin
            median_reg <= final_or;
        end
    end

    // Ring of raw samples in arrival order; supplies the sample to drop.
    swm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (in_fire),
        .waddr (tail_slot),
        .wdata (sample),
        .re    (ram_re),
        .raddr (oldest_reg),
        .rdata (ram_rdata)
    );

    assign up_link[0].gt           = 1'b0;
    assign up_link[0].valid        = 1'b1;
    assign up_link[0].value        = '0;
    assign dn_link[MAX_WINDOW].valid = 1'b0;
    assign dn_link[MAX_WINDOW].eq    = 1'b0;
    assign dn_link[MAX_WINDOW].value = '0;

    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        swm_cell #(
            .IDX    (i),
            .RANK_W (AW)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .op     (cell_op),
            .x      (x_reg),
            .d      (sample_t'(ram_rdata)),
            .rank   (rank),
            .lo_in  (up_link[i]),
            .hi_in  (dn_link[i+1]),
            .up_out (up_link[i+1]),
            .dn_out (dn_link[i]),
            .valid  (cell_valid[i]),
            .tap    (tap[i])
        );
    end

    // First level of the rank OR tree: groups of eight taps.
    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            group_next[g] = '0;
            for (int k = 0; k < 8; k++)
            begin
                if (g * 8 + k < MAX_WINDOW)
                begin
                    group_next[g] = group_next[g] | tap[g*8+k];
                end
            end
        end
    end

    always_comb
    begin
        final_or = '0;
        for (int g = 0; g < NG; g++)
        begin
            final_or = final_or | group_reg[g];
        end
    end

    assign out_valid = out_valid_reg;
    assign median    = median_reg;

    // Occupied cells form one run starting at cell 0.
    a_valid_run: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot({1'b0, cell_valid} + (MAX_WINDOW+1)'(1)))
        else $error("cell chain valid bits not contiguous");

    // Between beats the chain holds exactly the samples counted.
    a_fill_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ($countones(cell_valid) == 32'(fill_reg)))
        else $error("chain occupancy differs from fill count");

    // Between beats the window is never full.
    a_fill_below: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (fill_reg < w_eff))
        else $error("fill count reached window size while idle");

    // A new median only comes from the output step.
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("median raised outside output step");

endmodule
